>>> rtl/sobel_5x5_gradient_filter_assert.svh
// assertion macros for the 5x5 gradient filter checker
// no dependencies; pulled in by the checker file
`ifndef SOBEL_5X5_GRADIENT_FILTER_ASSERT_SVH
`define SOBEL_5X5_GRADIENT_FILTER_ASSERT_SVH

// same-cycle implication, off while reset is low
`define S5G_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gradient filter check failed");

// next-cycle implication, off while reset is low
`define S5G_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gradient filter check failed");

// next-cycle implication, also checked through reset
`define S5G_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gradient filter check failed");

`endif

>>> rtl/s5g_pkg.sv
// shared constants, column-sum type and register codes of the 5x5 gradient filter
// no dependencies
package s5g_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WSZ_W = COL_W + 1;
    localparam int HSZ_W = ROW_W + 1;

    localparam int WID_W     = 12;
    localparam int HGT_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int MIN_SIZE  = 5;
    localparam int BORDER    = 4;

    localparam int PIX_W     = 8;
    localparam int NUM_LINES = 4;
    localparam int TAPS      = 5;
    localparam int WORD_W    = PIX_W * NUM_LINES;

    localparam int SMOOTH_W      = 12;
    localparam int DERIV_W       = 11;
    localparam int GRAD_W        = 16;
    localparam int GRAD_SHIFT    = 7;
    localparam int NEAR_WEIGHT   = 4;
    localparam int CENTRE_WEIGHT = 6;

    localparam logic [PIX_W-1:0] GRAD_OFFSET = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic        [SMOOTH_W-1:0] smooth;
        logic signed [DERIV_W-1:0]  deriv;
    } t_col_sum;

endpackage

>>> rtl/s5g_ram.sv
// generic single-write, single-read ram with registered read (old data on collision)
// no dependencies
module s5g_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/s5g_col_reduce.sv
// vertical reduction of one 5-pixel column: 1,4,6,4,1 smoothing and 1,2,0,-2,-1 difference
// depends on s5g_pkg
module s5g_col_reduce
    import s5g_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  logic [PIX_W-1:0]  i_pixel,
    output t_col_sum          o_col
);

    logic [SMOOTH_W-1:0] u [TAPS];

    always_comb begin
        for (int k = 0; k < NUM_LINES; k++) begin
            u[k] = SMOOTH_W'(i_word[k*PIX_W +: PIX_W]);
        end
        u[NUM_LINES] = SMOOTH_W'(i_pixel);
    end

    // oldest row on top
    assign o_col.smooth = u[0] + u[1] * SMOOTH_W'(NEAR_WEIGHT) + u[2] * SMOOTH_W'(CENTRE_WEIGHT)
                        + u[3] * SMOOTH_W'(NEAR_WEIGHT) + u[4];

    assign o_col.deriv = $signed(DERIV_W'(u[0])) + ($signed(DERIV_W'(u[1])) <<< 1)
                       - ($signed(DERIV_W'(u[3])) <<< 1) - $signed(DERIV_W'(u[4]));

endmodule

>>> rtl/s5g_cell.sv
// one window cell: holds the reduced sums of one column, loads its right neighbor on shift
// depends on s5g_pkg
module s5g_cell
    import s5g_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_shift,
    input  t_col_sum i_data,
    output t_col_sum o_data
);

    t_col_sum r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

>>> rtl/s5g_grad_out.sv
// horizontal reduction over the five window cells and conversion to offset bytes
// depends on s5g_pkg
module s5g_grad_out
    import s5g_pkg::*;
(
    input  t_col_sum         i_win [TAPS],
    output logic [PIX_W-1:0] o_grad_x_byte,
    output logic [PIX_W-1:0] o_grad_y_byte
);

    localparam int PIX_MAX = (1 << PIX_W) - 1;

    logic signed [GRAD_W-1:0] es [TAPS];
    logic signed [GRAD_W-1:0] ed [TAPS];
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;

    // floor shift, offset, clamp to byte range
    function automatic logic [PIX_W-1:0] to_byte(input logic signed [GRAD_W-1:0] sum);
        logic signed [GRAD_W-1:0] q;
        q = (sum >>> GRAD_SHIFT) + $signed(GRAD_W'(GRAD_OFFSET));
        if (q < 0) begin
            return '0;
        end else if (q > PIX_MAX) begin
            return '1;
        end else begin
            return q[PIX_W-1:0];
        end
    endfunction

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            es[k] = $signed(GRAD_W'(i_win[k].smooth));
            ed[k] = $signed({{(GRAD_W-DERIV_W){i_win[k].deriv[DERIV_W-1]}}, i_win[k].deriv});
        end
    end

    // cell 0 is the oldest column
    assign gx = es[0] + (es[1] <<< 1) - (es[3] <<< 1) - es[4];
    assign gy = ed[0] + ed[1] * $signed(GRAD_W'(NEAR_WEIGHT))
              + ed[2] * $signed(GRAD_W'(CENTRE_WEIGHT))
              + ed[3] * $signed(GRAD_W'(NEAR_WEIGHT)) + ed[4];

    assign o_grad_x_byte = to_byte(gx);
    assign o_grad_y_byte = to_byte(gy);

endmodule

>>> rtl/sobel_5x5_gradient_filter.sv
// top level of the streaming 5x5 separable gradient filter
// depends on s5g_pkg, s5g_ram, s5g_col_reduce, s5g_cell, s5g_grad_out
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -------------------------------------------
//  in        sink       i_in_valid / o_in_ready    i_pixel, i_frame_start
//  out       source     o_out_valid / i_out_ready  o_grad_x_byte, o_grad_y_byte, o_centre_valid
//  cfg       sink       i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
//  one pixel per cycle sustained while the output takes results and no clearing sweep runs;
//  a result passes stage 1, stage 2 and the output register before it is offered
//  the rate is set by the line buffer ram: one read and one write-back of a 4-pixel column per cycle
//  after reset the line buffer is zeroed, one column a cycle, all 2048 columns with o_in_ready low
//  config writes are taken during that sweep as at any other time
//  an output stall fills the two inner stages, then o_in_ready drops until the result is taken
module sobel_5x5_gradient_filter
    import s5g_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_frame_start,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_grad_x_byte,
    output logic [PIX_W-1:0]     o_grad_y_byte,
    output logic                 o_centre_valid,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // image size, held already clamped to the legal range
    logic [WSZ_W-1:0] r_width;
    logic [HSZ_W-1:0] r_height;
    logic [WSZ_W-1:0] n_width;
    logic [HSZ_W-1:0] n_height;

    // line buffer clearing sweep
    logic             r_clr_busy;
    logic [COL_W-1:0] r_clr_addr;

    // raster position of the next pixel
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [WSZ_W-1:0] col_inc;
    logic [HSZ_W-1:0] row_inc;
    logic             centre_ok;

    // pipeline control
    logic accept;
    logic s1_adv;
    logic s2_adv;

    // stage 1: column read back from the line buffer
    logic              r_s1_vld;
    logic [COL_W-1:0]  r_s1_col;
    logic [PIX_W-1:0]  r_s1_px;
    logic              r_s1_cv;
    logic              r_s1_fwd;
    logic [WORD_W-1:0] r_s1_fwd_word;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] s1_word;
    logic [WORD_W-1:0] wr_word;
    logic              ram_we;
    logic [COL_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    t_col_sum          col_sum;

    // stage 2: window cells hold the updated window
    t_col_sum         win [TAPS];
    logic             r_s2_vld;
    logic             r_s2_cv;
    logic [PIX_W-1:0] gx_byte;
    logic [PIX_W-1:0] gy_byte;

    // output register
    logic             r_out_vld;
    logic [PIX_W-1:0] r_gx;
    logic [PIX_W-1:0] r_gy;
    logic             r_cv;

    //------------------------------------------------------------------
    // configuration
    //------------------------------------------------------------------
    always_comb begin
        logic [31:0] wv;
        logic [31:0] hv;
        wv = 32'(i_cfg_data[WID_W-1:0]);
        hv = 32'(i_cfg_data[HGT_W-1:0]);
        if (wv < 32'(MIN_SIZE)) begin
            n_width = WSZ_W'(MIN_SIZE);
        end else if (wv > 32'(MAX_WIDTH)) begin
            n_width = WSZ_W'(MAX_WIDTH);
        end else begin
            n_width = wv[WSZ_W-1:0];
        end
        if (hv < 32'(MIN_SIZE)) begin
            n_height = HSZ_W'(MIN_SIZE);
        end else if (hv > 32'(MAX_HEIGHT)) begin
            n_height = HSZ_W'(MAX_HEIGHT);
        end else begin
            n_height = hv[HSZ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WSZ_W'(640);
            r_height <= HSZ_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH: begin
                    r_width <= n_width;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= n_height;
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // handshake and stage advance
    //------------------------------------------------------------------
    assign s2_adv     = r_s2_vld && (!r_out_vld || i_out_ready);
    assign s1_adv     = r_s1_vld && (!r_s2_vld || s2_adv);
    assign o_in_ready = !r_clr_busy && (!r_s1_vld || s1_adv);
    assign accept     = i_in_valid && o_in_ready;

    //------------------------------------------------------------------
    // line buffer clearing after reset
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    //------------------------------------------------------------------
    // raster position and border test for the incoming pixel
    //------------------------------------------------------------------
    always_comb begin
        col_eff = i_frame_start ? '0 : r_col;
        row_eff = i_frame_start ? '0 : r_row;

        // window centre is interior only once four rows and columns are in
        centre_ok = (row_eff >= ROW_W'(BORDER)) && (col_eff >= COL_W'(BORDER))
                 && (HSZ_W'(row_eff) < r_height) && (WSZ_W'(col_eff) < r_width);

        col_inc = WSZ_W'(col_eff) + 1'b1;
        row_inc = HSZ_W'(row_eff) + 1'b1;
        if (col_inc >= r_width) begin
            n_col = '0;
            n_row = (row_inc >= r_height) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = row_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    //------------------------------------------------------------------
    // line buffer: one 4-pixel word per column, oldest row in the low byte
    //------------------------------------------------------------------
    assign ram_we    = r_clr_busy || s1_adv;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_col;
    assign ram_wdata = r_clr_busy ? '0 : wr_word;

    s5g_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (col_eff),
        .o_rdata (ram_rdata)
    );

    //------------------------------------------------------------------
    // stage 1
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // a read that meets the write-back of the same column in the same cycle
    // sees old data, so the written word is bypassed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= col_eff;
            r_s1_px       <= i_pixel;
            r_s1_cv       <= centre_ok;
            r_s1_fwd      <= s1_adv && (r_s1_col == col_eff);
            r_s1_fwd_word <= wr_word;
        end
    end

    assign s1_word = r_s1_fwd ? r_s1_fwd_word : ram_rdata;

    // rows move up by one, the new pixel becomes the newest row
    assign wr_word = {r_s1_px, s1_word[WORD_W-1:PIX_W]};

    s5g_col_reduce u_col_reduce (
        .i_word  (s1_word),
        .i_pixel (r_s1_px),
        .o_col   (col_sum)
    );

    //------------------------------------------------------------------
    // window: chain of cells, the newest column enters the last cell
    //------------------------------------------------------------------
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        if (g == TAPS - 1) begin : g_head
            s5g_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (s1_adv),
                .i_data  (col_sum),
                .o_data  (win[g])
            );
        end else begin : g_link
            s5g_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (s1_adv),
                .i_data  (win[g+1]),
                .o_data  (win[g])
            );
        end
    end

    //------------------------------------------------------------------
    // stage 2
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s2_vld <= 1'b1;
        end else if (s2_adv) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_cv <= r_s1_cv;
        end
    end

    s5g_grad_out u_grad_out (
        .i_win         (win),
        .o_grad_x_byte (gx_byte),
        .o_grad_y_byte (gy_byte)
    );

    //------------------------------------------------------------------
    // output register; border centres report zero gradient
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_gx <= r_s2_cv ? gx_byte : GRAD_OFFSET;
            r_gy <= r_s2_cv ? gy_byte : GRAD_OFFSET;
            r_cv <= r_s2_cv;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_grad_x_byte  = r_gx;
    assign o_grad_y_byte  = r_gy;
    assign o_centre_valid = r_cv;

endmodule

>>> rtl/s5g_chk.sv
// port-level checker for the 5x5 gradient filter, bound to the top level
// depends on sobel_5x5_gradient_filter_assert.svh and the top level's ports
`include "sobel_5x5_gradient_filter_assert.svh"

module s5g_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_grad_x_byte,
    input logic [7:0]  o_grad_y_byte,
    input logic        o_centre_valid
);

    // line buffer sweep keeps the input closed right after reset
    `S5G_ASSERT_NXT_ALWAYS(a_ready_low_after_reset, i_clk, !i_rst_n, !o_in_ready)

    // a stalled result holds
    `S5G_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_grad_x_byte) && $stable(o_grad_y_byte) && $stable(o_centre_valid))

    // border centres carry zero gradient
    `S5G_ASSERT_IMP(a_border_zero, i_clk, i_rst_n, o_out_valid && !o_centre_valid, o_grad_x_byte == 8'd128 && o_grad_y_byte == 8'd128)

    // interior gradients stay within the kernel's reach
    `S5G_ASSERT_IMP(a_grad_range, i_clk, i_rst_n, o_out_valid && o_centre_valid, o_grad_x_byte >= 8'd32 && o_grad_x_byte <= 8'd224 && o_grad_y_byte >= 8'd32 && o_grad_y_byte <= 8'd224)

endmodule

bind sobel_5x5_gradient_filter s5g_chk u_s5g_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_grad_x_byte  (o_grad_x_byte),
    .o_grad_y_byte  (o_grad_y_byte),
    .o_centre_valid (o_centre_valid)
);

>>> sim/testbench.sv
// self-checking bench for the streaming 5x5 separable gradient filter
// depends on s5g_pkg and sobel_5x5_gradient_filter; holds its own line-buffer predictor
`timescale 1ns / 100ps

module testbench;
    import s5g_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;  // covers the clear sweep of all 2048 columns and long stalls
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_STALL     = 300;
    localparam int STALL_AT_GRAD  = 150;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             first;
    } t_pixel_item;

    typedef struct packed {
        logic [PIX_W-1:0] grad_x;
        logic [PIX_W-1:0] grad_y;
        logic             centre_ok;
    } t_grad_result;

    // dut ports, the driven inputs all known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [PIX_W-1:0]     i_pixel       = '0;
    logic                 i_frame_start = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [PIX_W-1:0]     o_grad_x_byte;
    logic [PIX_W-1:0]     o_grad_y_byte;
    logic                 o_centre_valid;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // predictor state: four stored rows, two column windows, raster position, sizes
    logic [PIX_W-1:0]  line_hist [NUM_LINES][MAX_WIDTH];
    int                smooth_cols [TAPS];
    int                deriv_cols [TAPS];
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;

    // pixels waiting for the driver and gradients waiting for the dut
    t_pixel_item  pixel_backlog [$];
    t_grad_result expected_grads [$];

    // generator's own raster position, follows the same wrap rules as the block
    int unsigned gen_row = 0;
    int unsigned gen_col = 0;

    // idle percentages for the current stretch of the run
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    int pixels_taken   = 0;
    int grads_checked  = 0;
    int interior_grads = 0;
    int mismatches     = 0;
    int stall_left     = 0;
    bit long_stall_done = 1'b0;
    int quiet_cycles   = 0;

    sobel_5x5_gradient_filter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel        (i_pixel),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_grad_x_byte  (o_grad_x_byte),
        .o_grad_y_byte  (o_grad_y_byte),
        .o_centre_valid (o_centre_valid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // sizes below five or above the maximum are pinned to the nearest legal size
    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // floor shift, offset and clamp to a byte
    function automatic logic [PIX_W-1:0] offset_saturate(int sum);
        int q;
        q = (sum >>> GRAD_SHIFT) + int'(GRAD_OFFSET);
        if (q < 0) q = 0;
        else if (q > 255) q = 255;
        return q[PIX_W-1:0];
    endfunction

    // one pixel in, one gradient pair out, for the centre two rows and two columns back
    function automatic t_grad_result filter_pixel(logic [PIX_W-1:0] pix, logic first);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int           tap [TAPS];
        int           gx;
        int           gy;
        t_grad_result res;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (first) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= MAX_WIDTH) col_pos = 0;
        c = col_pos;

        // column of five: four stored rows, oldest on top, then the new pixel
        for (int k = 0; k < NUM_LINES; k++) tap[k] = int'(line_hist[k][c]);
        tap[NUM_LINES] = int'(pix);
        for (int k = 0; k < NUM_LINES - 1; k++) line_hist[k][c] = line_hist[k + 1][c];
        line_hist[NUM_LINES - 1][c] = pix;

        for (int k = 0; k < TAPS - 1; k++) begin
            smooth_cols[k] = smooth_cols[k + 1];
            deriv_cols[k]  = deriv_cols[k + 1];
        end
        smooth_cols[4] = tap[0] + NEAR_WEIGHT * tap[1] + CENTRE_WEIGHT * tap[2]
                       + NEAR_WEIGHT * tap[3] + tap[4];
        deriv_cols[4]  = tap[0] + 2 * tap[1] - 2 * tap[3] - tap[4];

        gx = smooth_cols[0] + 2 * smooth_cols[1] - 2 * smooth_cols[3] - smooth_cols[4];
        gy = deriv_cols[0] + NEAR_WEIGHT * deriv_cols[1] + CENTRE_WEIGHT * deriv_cols[2]
           + NEAR_WEIGHT * deriv_cols[3] + deriv_cols[4];

        // border centres and positions past a shrunk size give a flat result
        res.centre_ok = row_pos >= BORDER && col_pos >= BORDER && row_pos < h && col_pos < w;
        res.grad_x    = res.centre_ok ? offset_saturate(gx) : GRAD_OFFSET;
        res.grad_y    = res.centre_ok ? offset_saturate(gy) : GRAD_OFFSET;

        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    // pixel driver: holds the payload until the transfer, then maybe idles
    always @(posedge i_clk) begin : drive_pixels
        logic        offer;
        t_pixel_item item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                expected_grads.push_back(filter_pixel(i_pixel, i_frame_start));
                pixels_taken++;
                offer = 1'b0;
            end
            if (!offer && pixel_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                item = pixel_backlog.pop_front();
                i_pixel       <= item.pixel;
                i_frame_start <= item.first;
                offer = 1'b1;
            end
            // single assignment per edge so a back-to-back item keeps valid high
            i_in_valid <= offer;
        end
    end

    // result monitor and output back-pressure
    always @(posedge i_clk) begin : check_grads
        t_grad_result want;
        t_grad_result got;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_grad_x_byte, o_grad_y_byte, o_centre_valid};
                if (expected_grads.size() == 0) begin
                    $display("%0t: unexpected result gx=%0d gy=%0d valid=%0b", $time,
                             got.grad_x, got.grad_y, got.centre_ok);
                    mismatches++;
                end else begin
                    want = expected_grads.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected gx=%0d gy=%0d valid=%0b, got gx=%0d gy=%0d valid=%0b",
                                 $time, want.grad_x, want.grad_y, want.centre_ok,
                                 got.grad_x, got.grad_y, got.centre_ok);
                        mismatches++;
                    end
                end
                grads_checked++;
                if (got.centre_ok) interior_grads++;
            end

            // one long hold-off so the inner stages fill and the input stalls
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (grads_checked == STALL_AT_GRAD && !long_stall_done) begin
                long_stall_done = 1'b1;
                stall_left = LONG_STALL - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // wait until every pixel is taken and every gradient has come back
    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || i_in_valid || expected_grads.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // both size registers, back to back, mirrored into the predictor
    task automatic write_sizes(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= w;
        width_reg   = w[WID_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        height_reg  = h[HGT_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // raster pixels for the given sizes: mostly whole frames marked by a frame start,
    // some frames running on through the wrap, and a rare stray frame start
    task automatic queue_pixels(int count, int unsigned w, int unsigned h);
        t_pixel_item item;
        int          look;
        look = $urandom_range(4);
        repeat (count) begin
            item.first = 1'b0;
            if (gen_row == 0 && gen_col == 0) begin
                item.first = ($urandom_range(3) != 0);
                look = $urandom_range(4);
            end else if ($urandom_range(299) == 0) begin
                item.first = 1'b1;
                gen_row = 0;
                gen_col = 0;
            end
            case (look)
                2: item.pixel = $urandom_range(1) ? 8'hFF : 8'h00;
                3: item.pixel = (gen_col < w / 2) ? 8'hFF : 8'h00;  // vertical edge
                4: item.pixel = (gen_row < h / 2) ? 8'h00 : 8'hFF;  // horizontal edge
                default: item.pixel = PIX_W'($urandom_range(255));
            endcase
            pixel_backlog.push_back(item);
            if (gen_col + 1 >= w) begin
                gen_col = 0;
                gen_row = (gen_row + 1 >= h) ? 0 : gen_row + 1;
            end else begin
                gen_col++;
            end
        end
    endtask

    // new sizes only once the block has drained; the raster position carries over
    task automatic run_phase(int w, int h, int count);
        wait_idle();
        write_sizes(CFG_W'(w), CFG_W'(h));
        queue_pixels(count, clamp_dim(w, MAX_WIDTH), clamp_dim(h, MAX_HEIGHT));
    endtask

    initial begin
        t_pixel_item item;
        // predictor matches the block's reset state
        for (int k = 0; k < NUM_LINES; k++)
            for (int c = 0; c < MAX_WIDTH; c++) line_hist[k][c] = '0;
        for (int k = 0; k < TAPS; k++) begin
            smooth_cols[k] = 0;
            deriv_cols[k]  = 0;
        end
        row_pos    = 0;
        col_pos    = 0;
        width_reg  = 640;
        height_reg = 480;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles now and then, receiver mostly stalls
        send_gap_pct   = 10;
        recv_stall_pct = 72;

        // directed: smallest frame, extreme pixels, a corner of bright rows and columns
        wait_idle();
        write_sizes(CFG_W'(MIN_SIZE), CFG_W'(MIN_SIZE));
        for (int r = 0; r < MIN_SIZE; r++) begin
            for (int c = 0; c < MIN_SIZE; c++) begin
                item.first = (r == 0 && c == 0);
                item.pixel = (c < 2 || r >= 3) ? 8'hFF : 8'h00;
                pixel_backlog.push_back(item);
            end
        end

        repeat (4) run_phase($urandom_range(16, 5), $urandom_range(10, 5), 80);
        run_phase(0, 3, 60);  // both sizes below the minimum

        // sender mostly idles, receiver rarely stalls
        send_gap_pct   = 72;
        recv_stall_pct = 10;
        repeat (4) run_phase($urandom_range(24, 5), $urandom_range(12, 5), 80);
        run_phase(6, MAX_HEIGHT, 100);

        // full rate on both sides
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_phase(4095, 8191, 200);  // all-ones sizes, clamp to max
        run_phase(MAX_WIDTH, MIN_SIZE, 200);
        repeat (4) run_phase($urandom_range(20, 5), $urandom_range(12, 5), 80);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d pixels in, %0d gradient pairs checked, %0d with a full window",
                 pixels_taken, grads_checked, interior_grads);
        $display("sizes from the 5x5 minimum up to 2048 wide and 4096 tall, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/s5g_pkg.sv
rtl/s5g_ram.sv
rtl/s5g_col_reduce.sv
rtl/s5g_cell.sv
rtl/s5g_grad_out.sv
rtl/sobel_5x5_gradient_filter.sv
rtl/s5g_chk.sv
sim/testbench.sv
